// ===== sv/scr_pkg.sv =====
// shared types, codes and byte tables of the serial command responder
// no dependencies
package scr_pkg;

    localparam logic [7:0] CR_BYTE = 8'h0D;
    localparam logic [7:0] NL_BYTE = 8'h0A;
    localparam logic [7:0] ZERO_BYTE = 8'h00;
    localparam logic [7:0] DIGIT_BASE = 8'h30;

    localparam logic [1:0] KIND_TEMP = 2'd0;
    localparam logic [1:0] KIND_CHECK = 2'd1;
    localparam logic [1:0] KIND_NOMESS = 2'd2;

    localparam logic [3:0] LAST_IDX_TEMP = 4'd8;
    localparam logic [3:0] LAST_IDX_OTHER = 4'd7;

    typedef struct packed {
        logic take;
        logic adv;
    } t_cmd;

    typedef struct packed {
        logic term;
        logic last;
    } t_stat;

    // letters of the two command words
    function automatic logic [7:0] word_char(input logic sel_check, input logic [2:0] pos);
        logic [7:0] c;
        c = ZERO_BYTE;
        if (sel_check) begin
            unique case (pos)
                3'd0: c = "C";
                3'd1: c = "H";
                3'd2: c = "E";
                3'd3: c = "C";
                3'd4: c = "K";
                default: c = ZERO_BYTE;
            endcase
        end else begin
            unique case (pos)
                3'd0: c = "T";
                3'd1: c = "E";
                3'd2: c = "M";
                3'd3: c = "P";
                default: c = ZERO_BYTE;
            endcase
        end
        return c;
    endfunction

    // double dabble, three bcd digits
    function automatic logic [11:0] bin2bcd(input logic [7:0] v);
        logic [19:0] sh;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] >= 4'd5) sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] >= 4'd5) sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] >= 4'd5) sh[19:16] = sh[19:16] + 4'd3;
            sh = sh << 1;
        end
        return sh[19:8];
    endfunction

    // response text by kind and position
    function automatic logic [7:0] resp_byte(input logic [1:0] kind, input logic [3:0] idx,
                                             input logic [11:0] bcd);
        logic [7:0] c;
        c = NL_BYTE;
        unique case (kind)
            KIND_TEMP: begin
                unique case (idx)
                    4'd0: c = "V";
                    4'd1: c = "A";
                    4'd2: c = "L";
                    4'd3: c = "U";
                    4'd4: c = "E";
                    4'd5: c = DIGIT_BASE + {4'd0, bcd[11:8]};
                    4'd6: c = DIGIT_BASE + {4'd0, bcd[7:4]};
                    4'd7: c = DIGIT_BASE + {4'd0, bcd[3:0]};
                    default: c = NL_BYTE;
                endcase
            end
            KIND_CHECK: begin
                unique case (idx)
                    4'd0: c = "O";
                    4'd1: c = "N";
                    4'd2: c = "L";
                    4'd3: c = "I";
                    4'd4: c = "N";
                    4'd5: c = "E";
                    4'd6: c = ZERO_BYTE;
                    default: c = NL_BYTE;
                endcase
            end
            default: begin
                unique case (idx)
                    4'd0: c = "N";
                    4'd1: c = "O";
                    4'd2: c = "M";
                    4'd3: c = "E";
                    4'd4: c = "S";
                    4'd5: c = "S";
                    4'd6: c = ZERO_BYTE;
                    default: c = NL_BYTE;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/scr_ctrl.sv =====
// controller state machine: input acceptance and response sequencing
// depends on scr_pkg
module scr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  scr_pkg::t_stat i_stat,
    output scr_pkg::t_cmd  o_cmd
);
    import scr_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SEND = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    if (i_stat.term) n_state = S_SEND;
                end
            end
            S_SEND: begin
                if (!i_out_stall) begin
                    o_cmd.adv = 1'b1;
                    if (i_stat.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_SEND);

endmodule

// ===== sv/scr_dp.sv =====
// datapath: line match tracking, temperature digits and response byte index
// depends on scr_pkg
module scr_dp #(
    parameter int LINE_SLOTS = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  scr_pkg::t_cmd  i_cmd,
    output scr_pkg::t_stat o_stat,
    input  logic [7:0]    i_rx_byte,
    input  logic [9:0]    i_temp_sample,
    output logic [7:0]    o_tx_byte,
    output logic          o_last_byte
);
    import scr_pkg::*;

    localparam int CW = $clog2(LINE_SLOTS);

    logic [CW-1:0] r_count;
    logic [CW-1:0] r_eff_len;
    logic          r_zero_seen;
    logic          r_temp_m;
    logic          r_check_m;
    logic [1:0]    r_kind;
    logic [11:0]   r_bcd;
    logic [3:0]    r_idx;

    logic          term;
    logic          temp_hit;
    logic          check_hit;
    logic [1:0]    kind_now;
    logic          last;

    assign term = (r_count >= CW'(LINE_SLOTS - 1)) || (i_rx_byte == CR_BYTE);
    assign temp_hit = r_temp_m && (r_eff_len == CW'(4));
    assign check_hit = r_check_m && (r_eff_len == CW'(5));
    assign kind_now = temp_hit ? KIND_TEMP : (check_hit ? KIND_CHECK : KIND_NOMESS);
    assign last = (r_kind == KIND_TEMP) ? (r_idx == LAST_IDX_TEMP) : (r_idx == LAST_IDX_OTHER);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_eff_len <= '0;
            r_zero_seen <= 1'b0;
            r_temp_m <= 1'b1;
            r_check_m <= 1'b1;
            r_kind <= KIND_NOMESS;
            r_idx <= '0;
        end else if (i_cmd.take) begin
            if (term) begin
                r_kind <= kind_now;
                r_idx <= '0;
                r_count <= '0;
                r_eff_len <= '0;
                r_zero_seen <= 1'b0;
                r_temp_m <= 1'b1;
                r_check_m <= 1'b1;
            end else begin
                r_count <= r_count + CW'(1);
                if (!r_zero_seen) begin
                    if (i_rx_byte == ZERO_BYTE) begin
                        r_zero_seen <= 1'b1;
                    end else begin
                        r_eff_len <= r_count + CW'(1);
                        r_temp_m <= r_temp_m && (r_count < CW'(4)) &&
                                    (i_rx_byte == word_char(1'b0, r_count[2:0]));
                        r_check_m <= r_check_m && (r_count < CW'(5)) &&
                                     (i_rx_byte == word_char(1'b1, r_count[2:0]));
                    end
                end
            end
        end else if (i_cmd.adv) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take && term) begin
            r_bcd <= bin2bcd(i_temp_sample[7:0]);
        end
    end

    assign o_stat.term = term;
    assign o_stat.last = last;
    assign o_tx_byte = resp_byte(r_kind, r_idx, r_bcd);
    assign o_last_byte = last;

endmodule

// ===== sv/serial_command_responder_unit.sv =====
// Serial command responder. Each received byte is one input item. Bytes
// collect into a line that ends on a carriage return, or on the byte that
// arrives when LINE_SLOTS-1 bytes are held (that byte is dropped). A line
// that reads TEMP answers VALUE, three decimal digits of the low eight bits
// of i_temp_sample and a newline; CHECK answers ONLINE, a zero byte and a
// newline; anything else answers NOMESS, a zero byte and a newline. A zero
// byte inside a line ends the compared text. A terminator is followed by
// its 9 (TEMP) or 8 response items, one per cycle while the output is not
// stalled; the input stalls until the newline item has been taken, as the
// response sequencer walks the text one byte per cycle while not stalled.
// depends on scr_pkg, scr_ctrl, scr_dp
module serial_command_responder_unit #(
    parameter int LINE_SLOTS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic [9:0] i_temp_sample,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_last_byte
);
    import scr_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    scr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    scr_dp #(
        .LINE_SLOTS (LINE_SLOTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_rx_byte     (i_rx_byte),
        .i_temp_sample (i_temp_sample),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule
